>>> rtl/core/rafdc_pkg.sv
// ----------------------------------------------------------------------------
// rafdc_pkg
// Shared widths, codes and frame layout for the range/angle frame to drive
// command core.
// ----------------------------------------------------------------------------
package rafdc_pkg;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_LEN  = 10;
  localparam int CMD_IDX_W = $clog2(CMD_LEN);
  localparam int ANG_W    = BYTE_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd2;

  localparam logic [LIMIT_W-1:0] NEAR_RST  = 16'd100;
  localparam logic [LIMIT_W-1:0] FAR_RST   = 16'd2000;
  localparam logic [BYTE_W-1:0]  SPEED_RST = 8'h0c;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hD6;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h6D;
  localparam logic [BYTE_W-1:0] SYNC_A     = 8'hff;
  localparam logic [BYTE_W-1:0] SYNC_B     = 8'hfe;

  localparam logic [BYTE_W-1:0] TURN_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] TURN_RIGHT = 8'h02;
  localparam logic [BYTE_W-1:0] TURN_LEFT  = 8'h04;
  localparam logic [BYTE_W-1:0] TURN_BACK  = 8'h06;

  localparam logic signed [ANG_W-1:0] ANG_35  = 9'sd35;
  localparam logic signed [ANG_W-1:0] ANG_75  = 9'sd75;
  localparam logic signed [ANG_W-1:0] ANG_110 = 9'sd110;
  localparam logic signed [ANG_W-1:0] ANG_120 = 9'sd120;
  localparam logic signed [ANG_W-1:0] ANG_135 = 9'sd135;

  // one word of the command stream
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } rafdc_word_t;

  // command picked by the steering rule
  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] m;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    logic [BYTE_W-1:0] t;
  } rafdc_cmd_t;

  // FF FE m 00 x 00 y 00 00 t
  function automatic rafdc_word_t frame_word(input logic [CMD_IDX_W-1:0] idx,
                                             input rafdc_cmd_t c);
    rafdc_word_t w;
    w.last = (idx == CMD_IDX_W'(CMD_LEN - 1));
    case (idx)
      4'd0:    w.data = SYNC_A;
      4'd1:    w.data = SYNC_B;
      4'd2:    w.data = c.m;
      4'd4:    w.data = c.x;
      4'd6:    w.data = c.y;
      4'd9:    w.data = c.t;
      default: w.data = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/rafdc_in_if.sv
// ----------------------------------------------------------------------------
// rafdc_in_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface rafdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [rafdc_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/rafdc_out_if.sv
// ----------------------------------------------------------------------------
// rafdc_out_if
// Drive command byte channel.
// ----------------------------------------------------------------------------
interface rafdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rafdc_pkg::BYTE_W-1:0]  cmd_byte;
  logic                          frame_end;

  modport source (output valid, output cmd_byte, output frame_end, input ready);
  modport sink   (input valid, input cmd_byte, input frame_end, output ready);
endinterface

>>> rtl/core/rafdc_cfg_if.sv
// ----------------------------------------------------------------------------
// rafdc_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface rafdc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rafdc_pkg::CFG_IDX_W-1:0] index;
  logic [rafdc_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rafdc_parser.sv
// ----------------------------------------------------------------------------
// rafdc_parser
// Header hunt, payload capture and steering sector selection.
// ----------------------------------------------------------------------------
module rafdc_parser import rafdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic [LIMIT_W-1:0] near_limit,
  input  logic [LIMIT_W-1:0] far_limit,
  input  logic [BYTE_W-1:0]  speed_byte,
  output logic               final_byte,
  output rafdc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR2,
    PH_DLO,
    PH_DHI,
    PH_ANGA,
    PH_ANGB
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] dlo_r, dhi_r, anga_r;

  logic [LIMIT_W-1:0]     dist_val;
  logic signed [ANG_W-1:0] ang;
  logic                   go;
  logic                   last_sector;
  logic [BYTE_W-1:0]      sx, sy, st;

  always_comb begin
    case (phase_r)
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) phase_nxt = PH_DLO;
        else if (rx_byte == HDR_FIRST) phase_nxt = PH_HDR2;
        else phase_nxt = PH_HUNT;
      end
      PH_DLO:  phase_nxt = PH_DHI;
      PH_DHI:  phase_nxt = PH_ANGA;
      PH_ANGA: phase_nxt = PH_ANGB;
      PH_ANGB: phase_nxt = PH_HUNT;
      default: phase_nxt = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_DLO) dlo_r <= rx_byte;
    if (acc && phase_r == PH_DHI) dhi_r <= rx_byte;
    if (acc && phase_r == PH_ANGA) anga_r <= rx_byte;
  end

  assign final_byte = (phase_r == PH_ANGB);
  assign dist_val = {dhi_r, dlo_r};
  assign ang  = $signed({1'b0, anga_r}) - $signed({1'b0, rx_byte});
  assign go   = (dist_val > near_limit) && (dist_val < far_limit);

  // first matching sector wins; angles of exactly +-35, +-75 and +-110 match nothing
  always_comb begin
    cmd.hit     = 1'b1;
    last_sector = 1'b0;
    sx = '0;
    sy = '0;
    st = TURN_NONE;
    if (ang > -ANG_35 && ang < ANG_35) begin
      sy = speed_byte;
    end else if (ang > ANG_35 && ang < ANG_75) begin
      sx = speed_byte; sy = speed_byte;
    end else if (ang > ANG_75 && ang < ANG_110) begin
      sx = speed_byte;
    end else if (ang > ANG_110 && ang < ANG_135) begin
      sx = speed_byte; sy = speed_byte; st = TURN_RIGHT;
    end else if (ang > -ANG_75 && ang < -ANG_35) begin
      sx = speed_byte; sy = speed_byte; st = TURN_LEFT;
    end else if (ang > -ANG_110 && ang < -ANG_75) begin
      sx = speed_byte; st = TURN_LEFT;
    end else if (ang > -ANG_135 && ang < -ANG_110) begin
      sx = speed_byte; sy = speed_byte; st = TURN_BACK;
    end else if (ang < -ANG_120 || ang > ANG_120) begin
      sy = speed_byte; st = TURN_RIGHT; last_sector = 1'b1;
    end else begin
      cmd.hit = 1'b0;
    end

    if (go) begin
      cmd.m = 8'd1;
      cmd.x = sx;
      cmd.y = sy;
      cmd.t = st;
    end else begin
      cmd.m = last_sector ? 8'd0 : 8'd1;
      cmd.x = '0;
      cmd.y = '0;
      cmd.t = TURN_NONE;
    end
  end

endmodule

>>> rtl/core/rafdc_cell.sv
// ----------------------------------------------------------------------------
// rafdc_cell
// One stage of the command shift line: loads in parallel, shifts toward the
// output on each taken word.
// ----------------------------------------------------------------------------
module rafdc_cell import rafdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        shift,
  input  rafdc_word_t load_w,
  input  rafdc_word_t nbr_w,
  input  logic        nbr_vld,
  output rafdc_word_t word_r,
  output logic        vld_r
);

  logic vld_nxt;

  always_comb begin
    if (load) vld_nxt = 1'b1;
    else if (shift) vld_nxt = nbr_vld;
    else vld_nxt = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) word_r <= load_w;
    else if (shift) word_r <= nbr_w;
  end

endmodule

>>> rtl/core/range_angle_frame_to_drive_command_core.sv
// ----------------------------------------------------------------------------
// range_angle_frame_to_drive_command_core
// Parses D6 6D ranging frames and answers in-sector ones with drive commands.
// ----------------------------------------------------------------------------
// The core takes one received byte per clock. On the last payload byte of a
// frame whose angle falls in a sector, the ten command words are loaded at
// once into a ten-cell shift line and leave it one word per ready cycle at
// the head cell, the first one in the cycle after that byte is taken. That last
// payload byte is held off only while the previous command still has a word
// in the line that does not leave in that same cycle; all other bytes are
// taken every cycle. Configuration writes are always ready. No clearing pass.
// ----------------------------------------------------------------------------
module range_angle_frame_to_drive_command_core import rafdc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rafdc_in_if.sink     in_ch,
  rafdc_out_if.source  out_ch,
  rafdc_cfg_if.sink    cfg_ch
);

  logic [LIMIT_W-1:0] near_r, far_r;
  logic [BYTE_W-1:0]  speed_r;

  logic        in_acc;
  logic        final_byte;
  rafdc_cmd_t  cmd;
  logic        load;
  logic        shift;
  logic        line_free;

  rafdc_word_t words [CMD_LEN+1];
  logic [CMD_LEN:0] vld;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r  <= NEAR_RST;
      far_r   <= FAR_RST;
      speed_r <= SPEED_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_NEAR:  near_r  <= cfg_ch.data;
        CFG_FAR:   far_r   <= cfg_ch.data;
        CFG_SPEED: speed_r <= cfg_ch.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // line can take a new command when empty or emptying this cycle
  assign line_free    = !vld[0] || (!vld[1] && out_ch.ready);
  assign in_ch.ready  = !final_byte || line_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign load         = in_acc && final_byte && cmd.hit;
  assign shift        = vld[0] && out_ch.ready;

  rafdc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .rx_byte    (in_ch.rx_byte),
    .near_limit (near_r),
    .far_limit  (far_r),
    .speed_byte (speed_r),
    .final_byte (final_byte),
    .cmd        (cmd)
  );

  assign words[CMD_LEN] = '0;
  assign vld[CMD_LEN]   = 1'b0;

  for (genvar i = 0; i < CMD_LEN; i++) begin : g_cell
    rafdc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (load),
      .shift   (shift),
      .load_w  (frame_word(CMD_IDX_W'(i), cmd)),
      .nbr_w   (words[i+1]),
      .nbr_vld (vld[i+1]),
      .word_r  (words[i]),
      .vld_r   (vld[i])
    );
  end

  assign out_ch.valid     = vld[0];
  assign out_ch.cmd_byte  = words[0].data;
  assign out_ch.frame_end = words[0].last;

endmodule
